[rtl/core/dmsfr_pkg.sv]
// Shared types and constants for the dual-mode serial frame receiver.
`timescale 1ns / 1ps

package dmsfr_pkg;

   localparam int DMSFR_BUF_DEPTH = 256;

   localparam logic [7:0] HDR_BYTE  = 8'h6C;
   localparam logic [7:0] CR_BYTE   = 8'h0D;
   localparam logic [7:0] LF_BYTE   = 8'h0A;
   localparam logic [7:0] LEN_EXTRA = 8'd5;

   typedef enum logic [1:0] {
      FUNC_RX      = 2'd0,
      FUNC_RELEASE = 2'd1,
      FUNC_READ    = 2'd2
   } func_type;

   typedef struct packed {
      logic done;
      logic cr;
      logic mode;
   } status_type;

endpackage

[rtl/core/dual_mode_serial_frame_receiver_top.sv]
// Top level: input register, assembly state, buffer and result register.
//
//  Channel | Dir | Signals                      | Contents
//  req     | in  | req_tvalid/tready/tdata/tuser| tdata: rx_byte, read_index; tuser: func
//  rsp     | out | rsp_tvalid/tready/tdata      | status flags, byte_count, read_data
//
//  req passes input then result register; one transaction per cycle unless rsp is held.
//  The buffer read port is registered, so read_data lands with the status.
//  Reset: synchronous; clears status, count and both pipeline valids. Buffer keeps content.
//  Stall: a held rsp stalls the input register; req_tready drops only when both are full.
`timescale 1ns / 1ps

module dual_mode_serial_frame_receiver_top
   import dmsfr_pkg::*;
#(
   parameter int BUF_DEPTH = DMSFR_BUF_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] rx_byte, [15:8] read_index
   input  logic [1:0]  req_tuser,  // [1:0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata   // [0] frame_done, [1] cr_seen, [2] length_mode,
                                   // [10:3] byte_count, [18:11] read_data, [23:19] zero
);

   localparam int AW   = $clog2(BUF_DEPTH);
   localparam int CW   = $clog2(BUF_DEPTH + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;

   logic       s1_valid_ff;
   func_type   s1_func_ff;
   logic [7:0] s1_byte_ff;
   logic [7:0] s1_idx_ff;

   logic       rsp_valid_ff;
   status_type rsp_status_ff;
   logic [7:0] rsp_count_ff;
   logic       rsp_rd_ff;

   logic            advance;
   logic            accept;
   logic [CMPW-1:0] idx_wide;
   logic            in_range;
   logic            rd_en;
   logic [AW-1:0]   rd_addr;
   logic [7:0]      rd_data;
   logic            wr_en;
   logic [AW-1:0]   wr_addr;
   logic [7:0]      wr_data;
   status_type      status_next;
   logic [7:0]      count_next;

   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   assign idx_wide = CMPW'(s1_idx_ff);
   assign in_range = idx_wide < CMPW'(BUF_DEPTH);
   assign rd_addr  = idx_wide[AW-1:0];
   assign rd_en    = advance && s1_func_ff == FUNC_READ && in_range;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_func_ff <= func_type'(req_tuser);
         s1_byte_ff <= req_tdata[7:0];
         s1_idx_ff  <= req_tdata[15:8];
      end
   end

   dmsfr_ctrl #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .step       (advance),
      .func       (s1_func_ff),
      .rx_byte    (s1_byte_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .status_next(status_next),
      .count_next (count_next)
   );

   dmsfr_buf #(
      .BUF_DEPTH(BUF_DEPTH)
   ) u_buf (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff <= status_next;
         rsp_count_ff  <= count_next;
         rsp_rd_ff     <= rd_en;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, (rsp_rd_ff ? rd_data : 8'd0), rsp_count_ff,
                        rsp_status_ff.mode, rsp_status_ff.cr, rsp_status_ff.done};

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !s1_valid_ff)
      else $error("pipeline not empty after reset");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && rsp_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input taken while pipeline blocked");

   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("transaction lost between stages");

endmodule

[rtl/core/dmsfr_buf.sv]
// Receive buffer: one write port, one registered read port.
`timescale 1ns / 1ps

module dmsfr_buf
   import dmsfr_pkg::*;
#(
   parameter int BUF_DEPTH = DMSFR_BUF_DEPTH,
   localparam int AW = $clog2(BUF_DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [BUF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/dmsfr_ctrl.sv]
// Frame/line assembly state and its next-state logic.
`timescale 1ns / 1ps

module dmsfr_ctrl
   import dmsfr_pkg::*;
#(
   parameter int BUF_DEPTH = DMSFR_BUF_DEPTH,
   localparam int AW = $clog2(BUF_DEPTH)
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  func_type      func,
   input  logic [7:0]    rx_byte,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic [7:0]    wr_data,
   output status_type    status_next,
   output logic [7:0]    count_next
);

   localparam int CW   = $clog2(BUF_DEPTH + 1);
   localparam int CMPW = (CW > 8) ? CW : 8;

   logic [AW-1:0] cnt_ff, cnt_in;
   logic          done_ff, done_in;
   logic          cr_ff, cr_in;
   logic          mode_ff, mode_in;
   logic [7:0]    sec_ff, sec_in;

   logic [CW-1:0]   cnt_inc;
   logic [CMPW-1:0] cnt_wide;
   logic [7:0]      len;
   logic            hdr;
   logic            store;

   assign cnt_inc = CW'(cnt_ff) + CW'(1);
   assign hdr     = mode_ff || (cnt_ff == '0 && !cr_ff && rx_byte == HDR_BYTE);
   assign len     = ((cnt_ff == AW'(1)) ? rx_byte : sec_ff) + LEN_EXTRA;

   always_comb begin
      cnt_in  = cnt_ff;
      done_in = done_ff;
      cr_in   = cr_ff;
      mode_in = mode_ff;
      sec_in  = sec_ff;
      store   = 1'b0;
      unique case (func)
         FUNC_RX: begin
            if (!done_ff) begin
               if (hdr) begin
                  store   = 1'b1;
                  mode_in = 1'b1;
                  if (cnt_ff == AW'(1)) begin
                     sec_in = rx_byte;
                  end
                  if (cnt_inc == CW'(BUF_DEPTH)) begin
                     cnt_in  = '0;
                     cr_in   = 1'b0;
                     mode_in = 1'b0;
                  end else begin
                     cnt_in = cnt_inc[AW-1:0];
                  end
                  if (cnt_inc >= CW'(2) && CMPW'(cnt_in) == CMPW'(len)) begin
                     done_in = 1'b1;
                  end
               end else if (cr_ff) begin
                  if (rx_byte != LF_BYTE) begin
                     cnt_in  = '0;
                     cr_in   = 1'b0;
                     mode_in = 1'b0;
                  end else begin
                     done_in = 1'b1;
                  end
               end else if (rx_byte == CR_BYTE) begin
                  cr_in = 1'b1;
               end else begin
                  store = 1'b1;
                  if (cnt_inc == CW'(BUF_DEPTH)) begin
                     cnt_in  = '0;
                     cr_in   = 1'b0;
                     mode_in = 1'b0;
                  end else begin
                     cnt_in = cnt_inc[AW-1:0];
                  end
               end
            end
         end
         FUNC_RELEASE: begin
            cnt_in  = '0;
            cr_in   = 1'b0;
            mode_in = 1'b0;
            done_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
         cr_ff   <= 1'b0;
         mode_ff <= 1'b0;
      end else if (step) begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
         cr_ff   <= cr_in;
         mode_ff <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         sec_ff <= sec_in;
      end
   end

   assign cnt_wide    = CMPW'(cnt_in);
   assign wr_en       = step && store;
   assign wr_addr     = cnt_ff;
   assign wr_data     = rx_byte;
   assign status_next = '{done: done_in, cr: cr_in, mode: mode_in};
   assign count_next  = cnt_wide[7:0];

   // CR is only tracked for text lines
   a_cr_not_length: assert property (@(posedge clock) disable iff (reset)
      !(cr_ff && mode_ff))
      else $error("CR flag set during length frame");

   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      step && func == FUNC_RELEASE |=> !done_ff && !cr_ff && !mode_ff && cnt_ff == '0)
      else $error("release did not clear status");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      step && done_ff && func == FUNC_RX |=> done_ff && $stable(cnt_ff))
      else $error("byte changed state of a completed frame");

endmodule
